// ===== rtl/hmtn_pkg.sv =====
// Shared types, constants and helpers for the heightmap triangle normal block.
// No dependencies.
package hmtn_pkg;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_CNT_W  = 9;

    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_X        = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_Y        = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CELLS_PER_ROW = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CELL_ROWS     = 2'd3;

    localparam logic [31:0] ROUND_BIAS = 32'h0000_0800;

    typedef logic signed [31:0] height_t;
    typedef logic signed [15:0] comp_t;

    // Differences of one cell, ready for the multiplier stage.
    typedef struct packed {
        height_t ab;
        height_t dc;
        height_t e1;
        height_t e2;
        logic    odd;
        logic    last;
    } cell_terms_t;

    function automatic comp_t round12(input logic [31:0] v);
        logic [31:0] s;
        s = v + ROUND_BIAS;
        return comp_t'(s[27:12]);
    endfunction

endpackage

// ===== rtl/hmtn_normals.sv =====
// Multiplier stage and output register of the triangle normal pipeline.
// Depends on hmtn_pkg.
module hmtn_normals (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hmtn_pkg::cell_terms_t in_terms,
    input  logic signed [15:0]   step_x,
    input  logic signed [15:0]   step_y,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [15:0]   m_first_nx,
    output logic signed [15:0]   m_first_ny,
    output logic signed [15:0]   m_first_nz,
    output logic signed [15:0]   m_second_nx,
    output logic signed [15:0]   m_second_ny,
    output logic signed [15:0]   m_second_nz,
    output logic                 m_last_cell
);
    import hmtn_pkg::*;

    logic        prod_valid_reg;
    height_t     p_ab_dy_reg, p_ab_hdx_reg, p_dx_e1_reg;
    height_t     p_dc_dy_reg, p_dc_hdx_reg, p_dx_e2_reg;
    logic        prod_odd_reg, prod_last_reg;
    height_t     dxdy_reg;

    logic        out_valid_reg;
    comp_t       f_nx_reg, f_ny_reg, f_nz_reg, s_nx_reg, s_ny_reg, s_nz_reg;
    logic        last_reg;

    logic        out_ready, prod_ready;
    height_t     dx32, dy32, hdx32;
    logic signed [15:0] hdx;
    height_t     px, py, pz, qx, qy, qz;

    assign out_ready  = !out_valid_reg || m_ready;
    assign prod_ready = !prod_valid_reg || out_ready;
    assign in_ready   = prod_ready;

    assign hdx   = (step_x + $signed({15'd0, step_x[15]})) >>> 1;
    assign dx32  = {{16{step_x[15]}}, step_x};
    assign dy32  = {{16{step_y[15]}}, step_y};
    assign hdx32 = {{16{hdx[15]}}, hdx};

    assign px = p_ab_dy_reg;
    assign py = p_dx_e1_reg - p_ab_hdx_reg;
    assign pz = dxdy_reg + hdx32;
    assign qx = -p_dc_dy_reg;
    assign qy = p_dc_hdx_reg - p_dx_e2_reg;
    assign qz = dxdy_reg - hdx32;

    always_ff @(posedge aclk) begin
        dxdy_reg <= dx32 * dy32;
        if (prod_ready) begin
            p_ab_dy_reg   <= in_terms.ab * dy32;
            p_ab_hdx_reg  <= in_terms.ab * hdx32;
            p_dx_e1_reg   <= dx32 * in_terms.e1;
            p_dc_dy_reg   <= in_terms.dc * dy32;
            p_dc_hdx_reg  <= in_terms.dc * hdx32;
            p_dx_e2_reg   <= dx32 * in_terms.e2;
            prod_odd_reg  <= in_terms.odd;
            prod_last_reg <= in_terms.last;
        end
        if (out_ready) begin
            if (prod_odd_reg) begin
                f_nx_reg <= round12(qx);
                f_ny_reg <= round12(qy);
                f_nz_reg <= round12(qz);
                s_nx_reg <= round12(px);
                s_ny_reg <= round12(py);
                s_nz_reg <= round12(pz);
            end else begin
                f_nx_reg <= round12(px);
                f_ny_reg <= round12(py);
                f_nz_reg <= round12(pz);
                s_nx_reg <= round12(qx);
                s_ny_reg <= round12(qy);
                s_nz_reg <= round12(qz);
            end
            last_reg <= prod_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (prod_ready) begin
                prod_valid_reg <= in_valid;
            end
            if (out_ready) begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_first_nx  = f_nx_reg;
    assign m_first_ny  = f_ny_reg;
    assign m_first_nz  = f_nz_reg;
    assign m_second_nx = s_nx_reg;
    assign m_second_ny = s_ny_reg;
    assign m_second_nz = s_nz_reg;
    assign m_last_cell = last_reg;

endmodule

// ===== rtl/heightmap_triangle_normals.sv =====
// Top level: grid counters, row buffer memory and cell difference stage.
// Depends on hmtn_pkg and hmtn_normals.
//
// Heights stream in raster order, one transaction per cycle sustained while m_ready
// allows; the single row buffer memory is read and written at the same entry in
// the cycle a point is accepted, so there is no hazard between neighboring points.
// A completed cell leaves as one result transaction once it has passed the buffer
// read, difference, multiplier and output registers; points that complete no cell
// give no result. The row buffer needs no clearing pass after reset: row 0 of a
// grid fills it before it is read. Configuration writes take effect for the next
// accepted point and are made only while the block is idle, left to the user.
module heightmap_triangle_normals #(
    parameter int MAX_CELLS_PER_ROW = 256,
    parameter int MAX_CELL_ROWS     = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [hmtn_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [hmtn_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [31:0]                s_height,
    input  logic                              s_grid_start,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [15:0]                m_first_nx,
    output logic signed [15:0]                m_first_ny,
    output logic signed [15:0]                m_first_nz,
    output logic signed [15:0]                m_second_nx,
    output logic signed [15:0]                m_second_ny,
    output logic signed [15:0]                m_second_nz,
    output logic                              m_last_cell
);
    import hmtn_pkg::*;

    localparam int CW   = $clog2(MAX_CELLS_PER_ROW + 1);
    localparam int RW   = $clog2(MAX_CELL_ROWS + 1);
    localparam int CLW  = (CW > CFG_CNT_W) ? CW : CFG_CNT_W;
    localparam int RLW  = (RW > CFG_CNT_W) ? RW : CFG_CNT_W;
    localparam int DEPTH = MAX_CELLS_PER_ROW + 1;

    logic signed [15:0]   step_x_reg, step_y_reg;
    logic [CFG_CNT_W-1:0] cells_per_row_reg, cell_rows_reg;

    logic [CW-1:0] column_count_reg;
    logic [RW-1:0] row_count_reg;
    logic          odd_row_reg;
    height_t       left_reg, upper_left_reg;

    height_t       row_mem [DEPTH];
    height_t       b1_reg, c1_reg, d1_reg;
    logic          v1_reg, emit1_reg, odd1_reg, last1_reg;

    logic          v2_reg;
    cell_terms_t   terms2_reg, terms2_next;

    logic [CLW-1:0] cpr_ext, cpr_max_ext;
    logic [RLW-1:0] rows_ext, rows_max_ext;
    logic [CW-1:0]  cpr, cc, col;
    logic [RW-1:0]  rows, row;
    logic           odd, accept, ready2, ready3, leave1;

    assign cpr_ext      = CLW'(cells_per_row_reg);
    assign cpr_max_ext  = CLW'(MAX_CELLS_PER_ROW);
    assign rows_ext     = RLW'(cell_rows_reg);
    assign rows_max_ext = RLW'(MAX_CELL_ROWS);

    assign cpr  = (cpr_ext == '0) ? CW'(1) :
                  (cpr_ext > cpr_max_ext) ? CW'(MAX_CELLS_PER_ROW) : CW'(cpr_ext);
    assign rows = (rows_ext == '0) ? RW'(1) :
                  (rows_ext > rows_max_ext) ? RW'(MAX_CELL_ROWS) : RW'(rows_ext);

    assign cc  = s_grid_start ? '0 : column_count_reg;
    assign col = (cc > cpr) ? cpr : cc;
    assign row = s_grid_start ? '0 : row_count_reg;
    assign odd = s_grid_start ? 1'b0 : odd_row_reg;

    assign ready2  = !v2_reg || ready3;
    assign leave1  = v1_reg && (ready2 || !emit1_reg);
    assign s_ready = !v1_reg || leave1;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_x_reg        <= '0;
            step_y_reg        <= '0;
            cells_per_row_reg <= CFG_CNT_W'(1);
            cell_rows_reg     <= CFG_CNT_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_STEP_X:        step_x_reg        <= cfg_wr_data;
                CFG_STEP_Y:        step_y_reg        <= cfg_wr_data;
                CFG_CELLS_PER_ROW: cells_per_row_reg <= cfg_wr_data[CFG_CNT_W-1:0];
                CFG_CELL_ROWS:     cell_rows_reg     <= cfg_wr_data[CFG_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            row_mem[col] <= s_height;
            b1_reg       <= row_mem[col];
            c1_reg       <= left_reg;
            d1_reg       <= s_height;
            emit1_reg    <= (col != '0) && (row != '0);
            odd1_reg     <= odd;
            last1_reg    <= (col >= cpr) && (row >= rows);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            odd_row_reg      <= 1'b0;
            left_reg         <= '0;
        end else if (accept) begin
            left_reg <= s_height;
            if (col >= cpr) begin
                column_count_reg <= '0;
                if (row >= rows) begin
                    row_count_reg <= '0;
                    odd_row_reg   <= 1'b0;
                end else begin
                    row_count_reg <= row + RW'(1);
                    odd_row_reg   <= odd ^ (row != '0);
                end
            end else begin
                column_count_reg <= col + CW'(1);
                row_count_reg    <= row;
                odd_row_reg      <= odd;
            end
        end
    end

    always_comb begin
        terms2_next.ab   = upper_left_reg - b1_reg;
        terms2_next.dc   = d1_reg - c1_reg;
        terms2_next.e1   = odd1_reg ? (d1_reg - b1_reg) : (c1_reg - b1_reg);
        terms2_next.e2   = odd1_reg ? (upper_left_reg - c1_reg) : (b1_reg - c1_reg);
        terms2_next.odd  = odd1_reg;
        terms2_next.last = last1_reg;
    end

    always_ff @(posedge aclk) begin
        if (ready2) begin
            terms2_reg <= terms2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            upper_left_reg <= '0;
        end else begin
            if (s_ready) begin
                v1_reg <= s_valid;
            end
            if (leave1) begin
                upper_left_reg <= b1_reg;
            end
            if (ready2) begin
                v2_reg <= v1_reg && emit1_reg;
            end
        end
    end

    hmtn_normals u_normals (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (v2_reg),
        .in_ready    (ready3),
        .in_terms    (terms2_reg),
        .step_x      (step_x_reg),
        .step_y      (step_y_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_first_nx  (m_first_nx),
        .m_first_ny  (m_first_ny),
        .m_first_nz  (m_first_nz),
        .m_second_nx (m_second_nx),
        .m_second_ny (m_second_ny),
        .m_second_nz (m_second_nz),
        .m_last_cell (m_last_cell)
    );

endmodule
